// File: hw/rtl/sm83cf_pkg.sv
// Package for the SM83 control-flow unit: input and result word types,
// opcode constants and the interrupt-enable action codes.
// No dependencies.
package sm83cf_pkg;

  typedef struct packed {
    logic [7:0]  req_type;
    logic [15:0] imm_value;
    logic [15:0] pc;
    logic [15:0] sp;
    logic [15:0] hl;
    logic [7:0]  reg_a;
    logic [7:0]  operand_byte;
    logic [15:0] pair_value;
    logic [15:0] stack_word;
    logic [3:0]  flags_in;
    logic [4:0]  cycles_taken;
    logic [4:0]  cycles_not_taken;
  } sm83cf_in_t;

  typedef enum logic [1:0] {
    IME_NONE    = 2'd0,
    IME_DISABLE = 2'd1,
    IME_ENABLE  = 2'd2
  } ime_action_t;

  typedef struct packed {
    logic [15:0] next_pc;
    logic [15:0] next_sp;
    logic [4:0]  cycle_count;
    logic        stack_write;
    logic [15:0] write_addr;
    logic [15:0] write_data;
    logic        pop_valid;
    logic [15:0] pop_value;
    logic [3:0]  flags_out;
    ime_action_t ime_action;
    logic        halt_request;
    logic        handled;
  } sm83cf_out_t;

  localparam logic [7:0] OP_NOP    = 8'h00;
  localparam logic [7:0] OP_JP     = 8'hC3;
  localparam logic [7:0] OP_JP_NZ  = 8'hC2;
  localparam logic [7:0] OP_JP_Z   = 8'hCA;
  localparam logic [7:0] OP_JP_NC  = 8'hD2;
  localparam logic [7:0] OP_JP_C   = 8'hDA;
  localparam logic [7:0] OP_JP_HL  = 8'hE9;
  localparam logic [7:0] OP_JR     = 8'h18;
  localparam logic [7:0] OP_JR_NZ  = 8'h20;
  localparam logic [7:0] OP_JR_Z   = 8'h28;
  localparam logic [7:0] OP_JR_NC  = 8'h30;
  localparam logic [7:0] OP_JR_C   = 8'h38;
  localparam logic [7:0] OP_CALL    = 8'hCD;
  localparam logic [7:0] OP_CALL_NZ = 8'hC4;
  localparam logic [7:0] OP_CALL_Z  = 8'hCC;
  localparam logic [7:0] OP_CALL_NC = 8'hD4;
  localparam logic [7:0] OP_CALL_C  = 8'hDC;
  localparam logic [7:0] OP_RET    = 8'hC9;
  localparam logic [7:0] OP_RETI   = 8'hD9;
  localparam logic [7:0] OP_RET_NZ = 8'hC0;
  localparam logic [7:0] OP_RET_Z  = 8'hC8;
  localparam logic [7:0] OP_RET_NC = 8'hD0;
  localparam logic [7:0] OP_RET_C  = 8'hD8;
  localparam logic [7:0] OP_RST_00 = 8'hC7;
  localparam logic [7:0] OP_RST_08 = 8'hCF;
  localparam logic [7:0] OP_RST_10 = 8'hD7;
  localparam logic [7:0] OP_RST_18 = 8'hDF;
  localparam logic [7:0] OP_RST_20 = 8'hE7;
  localparam logic [7:0] OP_RST_28 = 8'hEF;
  localparam logic [7:0] OP_RST_30 = 8'hF7;
  localparam logic [7:0] OP_RST_38 = 8'hFF;
  localparam logic [7:0] OP_PUSH_BC = 8'hC5;
  localparam logic [7:0] OP_PUSH_DE = 8'hD5;
  localparam logic [7:0] OP_PUSH_HL = 8'hE5;
  localparam logic [7:0] OP_PUSH_AF = 8'hF5;
  localparam logic [7:0] OP_POP_BC  = 8'hC1;
  localparam logic [7:0] OP_POP_DE  = 8'hD1;
  localparam logic [7:0] OP_POP_HL  = 8'hE1;
  localparam logic [7:0] OP_POP_AF  = 8'hF1;
  localparam logic [7:0] OP_CP_B   = 8'hB8;
  localparam logic [7:0] OP_CP_C   = 8'hB9;
  localparam logic [7:0] OP_CP_D   = 8'hBA;
  localparam logic [7:0] OP_CP_E   = 8'hBB;
  localparam logic [7:0] OP_CP_H   = 8'hBC;
  localparam logic [7:0] OP_CP_L   = 8'hBD;
  localparam logic [7:0] OP_CP_MHL = 8'hBE;
  localparam logic [7:0] OP_CP_A   = 8'hBF;
  localparam logic [7:0] OP_CP_IMM = 8'hFE;
  localparam logic [7:0] OP_DI     = 8'hF3;
  localparam logic [7:0] OP_EI     = 8'hFB;
  localparam logic [7:0] OP_HALT   = 8'h76;

  localparam logic [1:0] COND_NZ = 2'd0;
  localparam logic [1:0] COND_Z  = 2'd1;
  localparam logic [1:0] COND_NC = 2'd2;
  localparam logic [1:0] COND_C  = 2'd3;

endpackage

// File: hw/rtl/sm83cf_exec.sv
// Combinational execution of one SM83 control-flow instruction word.
// Depends on sm83cf_pkg.
module sm83cf_exec import sm83cf_pkg::*; (
  input  sm83cf_in_t  in_word,
  output sm83cf_out_t out_word
);

  logic [7:0]  op;
  logic [15:0] sp_m2;
  logic [15:0] sp_p2;
  logic [15:0] jr_target;
  logic        z_flag;
  logic        c_flag;
  logic        cond_ok;
  logic        uncond;
  logic        taken;

  assign op        = in_word.req_type;
  assign sp_m2     = in_word.sp - 16'd2;
  assign sp_p2     = in_word.sp + 16'd2;
  assign jr_target = in_word.pc + {{8{in_word.imm_value[7]}}, in_word.imm_value[7:0]};
  assign z_flag    = in_word.flags_in[3];
  assign c_flag    = in_word.flags_in[0];

  always_comb begin
    case (op[4:3])
      COND_NZ: cond_ok = !z_flag;
      COND_Z:  cond_ok = z_flag;
      COND_NC: cond_ok = !c_flag;
      COND_C:  cond_ok = c_flag;
      default: cond_ok = 1'b0;
    endcase
  end

  assign uncond = (op == OP_JP) || (op == OP_JR) || (op == OP_CALL) ||
                  (op == OP_RET) || (op == OP_RETI);
  assign taken  = uncond || cond_ok;

  always_comb begin
    out_word              = '0;
    out_word.next_pc      = in_word.pc;
    out_word.next_sp      = in_word.sp;
    out_word.flags_out    = in_word.flags_in;
    out_word.cycle_count  = in_word.cycles_taken;
    out_word.ime_action   = IME_NONE;
    out_word.handled      = 1'b1;
    case (op)
      OP_NOP: begin
      end
      OP_JP, OP_JP_NZ, OP_JP_Z, OP_JP_NC, OP_JP_C: begin
        if (taken) out_word.next_pc = in_word.imm_value;
        else out_word.cycle_count = in_word.cycles_not_taken;
      end
      OP_JP_HL: begin
        out_word.next_pc = in_word.hl;
      end
      OP_JR, OP_JR_NZ, OP_JR_Z, OP_JR_NC, OP_JR_C: begin
        if (taken) out_word.next_pc = jr_target;
        else out_word.cycle_count = in_word.cycles_not_taken;
      end
      OP_CALL, OP_CALL_NZ, OP_CALL_Z, OP_CALL_NC, OP_CALL_C: begin
        if (taken) begin
          out_word.stack_write = 1'b1;
          out_word.write_addr  = sp_m2;
          out_word.write_data  = in_word.pc;
          out_word.next_sp     = sp_m2;
          out_word.next_pc     = in_word.imm_value;
        end else begin
          out_word.cycle_count = in_word.cycles_not_taken;
        end
      end
      OP_RET, OP_RETI, OP_RET_NZ, OP_RET_Z, OP_RET_NC, OP_RET_C: begin
        if (taken) begin
          out_word.next_pc = in_word.stack_word;
          out_word.next_sp = sp_p2;
        end else begin
          out_word.cycle_count = in_word.cycles_not_taken;
        end
        if (op == OP_RETI) out_word.ime_action = IME_ENABLE;
      end
      OP_RST_00, OP_RST_08, OP_RST_10, OP_RST_18,
      OP_RST_20, OP_RST_28, OP_RST_30, OP_RST_38: begin
        out_word.stack_write = 1'b1;
        out_word.write_addr  = sp_m2;
        out_word.write_data  = in_word.pc;
        out_word.next_sp     = sp_m2;
        out_word.next_pc     = {10'd0, op[5:3], 3'd0};
      end
      OP_PUSH_BC, OP_PUSH_DE, OP_PUSH_HL, OP_PUSH_AF: begin
        out_word.stack_write = 1'b1;
        out_word.write_addr  = sp_m2;
        out_word.write_data  = in_word.pair_value;
        out_word.next_sp     = sp_m2;
      end
      OP_POP_BC, OP_POP_DE, OP_POP_HL, OP_POP_AF: begin
        out_word.pop_valid = 1'b1;
        out_word.pop_value = in_word.stack_word;
        out_word.next_sp   = sp_p2;
      end
      OP_CP_B, OP_CP_C, OP_CP_D, OP_CP_E, OP_CP_H, OP_CP_L,
      OP_CP_MHL, OP_CP_A, OP_CP_IMM: begin
        out_word.flags_out = {in_word.reg_a == in_word.operand_byte, 1'b1,
                              in_word.reg_a[3:0] < in_word.operand_byte[3:0],
                              in_word.reg_a < in_word.operand_byte};
      end
      OP_DI: begin
        out_word.ime_action = IME_DISABLE;
      end
      OP_EI: begin
        out_word.ime_action = IME_ENABLE;
      end
      OP_HALT: begin
        out_word.halt_request = 1'b1;
      end
      default: begin
        out_word.handled     = 1'b0;
        out_word.cycle_count = 5'd0;
      end
    endcase
  end

endmodule

// File: hw/rtl/sm83_control_flow_unit_core.sv
// Top level of the SM83 control-flow unit: input register, execution logic
// and result register. Depends on sm83cf_pkg and sm83cf_exec.

// The unit takes one instruction word in every cycle in which start is high;
// busy is always low. The accepting edge loads the word into the input
// register, the execution logic works on it, and the next edge loads the
// result register. The result word is then on out_word with out_strobe high
// for one cycle. Results come out in order and the receiver must take each
// one when it is shown.
module sm83_control_flow_unit_core import sm83cf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  sm83cf_in_t  in_word,
  output logic        out_strobe,
  output sm83cf_out_t out_word
);

  sm83cf_in_t  in_word_r;
  logic        in_vld_r;
  sm83cf_out_t exec_word;
  sm83cf_out_t out_word_r;
  logic        out_vld_r;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= start && !busy;
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) in_word_r <= in_word;
    if (in_vld_r) out_word_r <= exec_word;
  end

  sm83cf_exec u_exec (
    .in_word  (in_word_r),
    .out_word (exec_word)
  );

  assign out_strobe = out_vld_r;
  assign out_word   = out_word_r;

  a_two_cycle_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##2 out_strobe)
    else $error("accepted word did not produce a result two cycles later");

  a_write_matches_sp: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_word.stack_write) |->
      (out_word.write_addr == out_word.next_sp))
    else $error("stack write address differs from the new stack pointer");

  a_unhandled_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_word.handled) |->
      (out_word.cycle_count == 5'd0 && !out_word.stack_write && !out_word.pop_valid))
    else $error("unhandled opcode produced side effects");

endmodule

// File: bench/sm83_control_flow_unit_core_test.sv
`timescale 1ns / 1ps
// Self-checking bench for sm83_control_flow_unit_core: a queue-fed driver, a monitor
// that predicts each result word from the accepted instruction, and a stall watchdog.
// Depends on sm83cf_pkg and the control-flow unit RTL.
module sm83_control_flow_unit_core_test;
  import sm83cf_pkg::*;

  localparam logic [7:0] OP_UNUSED = 8'hD3;
  localparam int unsigned STALL_LIMIT = 1000;
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned RANDOM_WORDS = 1330;

  typedef struct {
    int unsigned gap;
    sm83cf_in_t  word;
  } issue_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  sm83cf_in_t  in_word;
  logic        out_strobe;
  sm83cf_out_t out_word;

  issue_t      instr_q[$];
  sm83cf_out_t expected_results[$];
  logic [7:0]  flow_ops[$];
  logic [15:0] sp_edges[$];

  issue_t      nxt;
  bit          have_next;
  int unsigned idle_left;
  logic        in_taken;
  int unsigned n_issued;
  int unsigned n_checked;
  int unsigned n_unknown;
  int unsigned n_errors;
  int unsigned stall_cycles;

  sm83_control_flow_unit_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_word    (in_word),
    .out_strobe (out_strobe),
    .out_word   (out_word)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic bit cond_met(logic [7:0] op, logic [3:0] flags);
    case (op[4:3])
      COND_NZ: return !flags[3];
      COND_Z:  return flags[3];
      COND_NC: return !flags[0];
      default: return flags[0];
    endcase
  endfunction

  function automatic sm83cf_out_t execute_flow(sm83cf_in_t w);
    sm83cf_out_t r;
    logic [15:0] sp_dn;
    logic [15:0] sp_up;
    r = '0;
    sp_dn = w.sp - 16'd2;
    sp_up = w.sp + 16'd2;
    r.next_pc = w.pc;
    r.next_sp = w.sp;
    r.flags_out = w.flags_in;
    r.cycle_count = w.cycles_taken;
    r.ime_action = IME_NONE;
    r.handled = 1'b1;
    case (w.req_type)
      OP_NOP: begin
      end
      OP_JP, OP_JP_NZ, OP_JP_Z, OP_JP_NC, OP_JP_C: begin
        if (w.req_type == OP_JP || cond_met(w.req_type, w.flags_in)) r.next_pc = w.imm_value;
        else r.cycle_count = w.cycles_not_taken;
      end
      OP_JP_HL: r.next_pc = w.hl;
      OP_JR, OP_JR_NZ, OP_JR_Z, OP_JR_NC, OP_JR_C: begin
        if (w.req_type == OP_JR || cond_met(w.req_type, w.flags_in))
          r.next_pc = w.pc + {{8{w.imm_value[7]}}, w.imm_value[7:0]};
        else r.cycle_count = w.cycles_not_taken;
      end
      OP_CALL, OP_CALL_NZ, OP_CALL_Z, OP_CALL_NC, OP_CALL_C: begin
        if (w.req_type == OP_CALL || cond_met(w.req_type, w.flags_in)) begin
          r.stack_write = 1'b1;
          r.write_addr = sp_dn;
          r.write_data = w.pc;
          r.next_sp = sp_dn;
          r.next_pc = w.imm_value;
        end else begin
          r.cycle_count = w.cycles_not_taken;
        end
      end
      OP_RET, OP_RETI, OP_RET_NZ, OP_RET_Z, OP_RET_NC, OP_RET_C: begin
        if (w.req_type == OP_RET || w.req_type == OP_RETI ||
            cond_met(w.req_type, w.flags_in)) begin
          r.next_pc = w.stack_word;
          r.next_sp = sp_up;
        end else begin
          r.cycle_count = w.cycles_not_taken;
        end
        if (w.req_type == OP_RETI) r.ime_action = IME_ENABLE;
      end
      OP_RST_00, OP_RST_08, OP_RST_10, OP_RST_18,
      OP_RST_20, OP_RST_28, OP_RST_30, OP_RST_38: begin
        r.stack_write = 1'b1;
        r.write_addr = sp_dn;
        r.write_data = w.pc;
        r.next_sp = sp_dn;
        r.next_pc = {10'd0, w.req_type[5:3], 3'd0};
      end
      OP_PUSH_BC, OP_PUSH_DE, OP_PUSH_HL, OP_PUSH_AF: begin
        r.stack_write = 1'b1;
        r.write_addr = sp_dn;
        r.write_data = w.pair_value;
        r.next_sp = sp_dn;
      end
      OP_POP_BC, OP_POP_DE, OP_POP_HL, OP_POP_AF: begin
        r.pop_valid = 1'b1;
        r.pop_value = w.stack_word;
        r.next_sp = sp_up;
      end
      OP_CP_B, OP_CP_C, OP_CP_D, OP_CP_E, OP_CP_H, OP_CP_L, OP_CP_MHL, OP_CP_A,
      OP_CP_IMM: begin
        r.flags_out = {w.reg_a == w.operand_byte, 1'b1,
                       w.reg_a[3:0] < w.operand_byte[3:0], w.reg_a < w.operand_byte};
      end
      OP_DI: r.ime_action = IME_DISABLE;
      OP_EI: r.ime_action = IME_ENABLE;
      OP_HALT: r.halt_request = 1'b1;
      default: begin
        r.handled = 1'b0;
        r.cycle_count = '0;
      end
    endcase
    return r;
  endfunction

  function automatic sm83cf_in_t random_word();
    sm83cf_in_t w;
    w.req_type = 8'($urandom);
    w.imm_value = 16'($urandom);
    w.pc = 16'($urandom);
    w.sp = 16'($urandom);
    w.hl = 16'($urandom);
    w.reg_a = 8'($urandom);
    w.operand_byte = 8'($urandom);
    w.pair_value = 16'($urandom);
    w.stack_word = 16'($urandom);
    w.flags_in = 4'($urandom);
    w.cycles_taken = 5'($urandom);
    w.cycles_not_taken = 5'($urandom);
    return w;
  endfunction

  function automatic sm83cf_in_t directed_word(logic [7:0] op, logic [3:0] flags);
    sm83cf_in_t w;
    w = random_word();
    w.req_type = op;
    w.flags_in = flags;
    return w;
  endfunction

  task automatic queue_word(sm83cf_in_t w, int unsigned gap);
    issue_t it;
    it.gap = gap;
    it.word = w;
    instr_q.push_back(it);
  endtask

  task automatic report_mismatch(string field, logic [15:0] got, logic [15:0] want);
    $display("mismatch in %s of result %0d: got %h, expected %h", field, n_checked, got, want);
    n_errors++;
  endtask

  task automatic check_result(sm83cf_out_t got, sm83cf_out_t want);
    if (got.next_pc !== want.next_pc) report_mismatch("next_pc", got.next_pc, want.next_pc);
    if (got.next_sp !== want.next_sp) report_mismatch("next_sp", got.next_sp, want.next_sp);
    if (got.cycle_count !== want.cycle_count)
      report_mismatch("cycle_count", 16'(got.cycle_count), 16'(want.cycle_count));
    if (got.stack_write !== want.stack_write)
      report_mismatch("stack_write", 16'(got.stack_write), 16'(want.stack_write));
    if (got.write_addr !== want.write_addr)
      report_mismatch("write_addr", got.write_addr, want.write_addr);
    if (got.write_data !== want.write_data)
      report_mismatch("write_data", got.write_data, want.write_data);
    if (got.pop_valid !== want.pop_valid)
      report_mismatch("pop_valid", 16'(got.pop_valid), 16'(want.pop_valid));
    if (got.pop_value !== want.pop_value)
      report_mismatch("pop_value", got.pop_value, want.pop_value);
    if (got.flags_out !== want.flags_out)
      report_mismatch("flags_out", 16'(got.flags_out), 16'(want.flags_out));
    if (got.ime_action !== want.ime_action)
      report_mismatch("ime_action", 16'(got.ime_action), 16'(want.ime_action));
    if (got.halt_request !== want.halt_request)
      report_mismatch("halt_request", 16'(got.halt_request), 16'(want.halt_request));
    if (got.handled !== want.handled)
      report_mismatch("handled", 16'(got.handled), 16'(want.handled));
  endtask

  // The driver presents the next word at the falling edge once the previous one was taken and its gap has run out.
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || in_taken) begin
      if (!have_next && instr_q.size() != 0) begin
        nxt = instr_q.pop_front();
        idle_left = nxt.gap;
        have_next = 1'b1;
      end
      if (have_next && idle_left == 0) begin
        in_word <= nxt.word;
        start <= 1'b1;
        have_next = 1'b0;
      end else begin
        start <= 1'b0;
        if (idle_left > 0) idle_left--;
      end
    end
  end

  always @(posedge clk) begin
    in_taken <= rst_n && start && !busy;
    if (rst_n && out_strobe) begin
      if (expected_results.size() == 0) begin
        $display("unexpected result word: next_pc %h", out_word.next_pc);
        n_errors++;
      end else begin
        check_result(out_word, expected_results.pop_front());
        n_checked++;
      end
    end
    if (rst_n && start && !busy) begin
      expected_results.push_back(execute_flow(in_word));
      if (!execute_flow(in_word).handled) n_unknown++;
      n_issued++;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_strobe) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("no progress for %0d cycles", STALL_LIMIT);
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    sm83cf_in_t w;
    int unsigned total;
    int unsigned gap;
    rst_n = 1'b0;
    start = 1'b0;
    in_word = '0;
    have_next = 1'b0;
    idle_left = 0;
    in_taken = 1'b0;
    n_issued = 0;
    n_checked = 0;
    n_unknown = 0;
    n_errors = 0;
    stall_cycles = 0;
    flow_ops = '{OP_NOP, OP_JP, OP_JP_NZ, OP_JP_Z, OP_JP_NC, OP_JP_C, OP_JP_HL,
                 OP_JR, OP_JR_NZ, OP_JR_Z, OP_JR_NC, OP_JR_C,
                 OP_CALL, OP_CALL_NZ, OP_CALL_Z, OP_CALL_NC, OP_CALL_C,
                 OP_RET, OP_RETI, OP_RET_NZ, OP_RET_Z, OP_RET_NC, OP_RET_C,
                 OP_RST_00, OP_RST_08, OP_RST_10, OP_RST_18,
                 OP_RST_20, OP_RST_28, OP_RST_30, OP_RST_38,
                 OP_PUSH_BC, OP_PUSH_DE, OP_PUSH_HL, OP_PUSH_AF,
                 OP_POP_BC, OP_POP_DE, OP_POP_HL, OP_POP_AF,
                 OP_CP_B, OP_CP_C, OP_CP_D, OP_CP_E, OP_CP_H, OP_CP_L, OP_CP_MHL,
                 OP_CP_A, OP_CP_IMM, OP_DI, OP_EI, OP_HALT};
    sp_edges = '{16'h0000, 16'h0001, 16'hFFFE, 16'hFFFF};

    w = '0; w.req_type = OP_NOP; queue_word(w, 0);
    w = '1; w.req_type = OP_UNUSED; queue_word(w, 0);
    w = directed_word(OP_JP, 4'h0); w.imm_value = 16'hFFFF; queue_word(w, 0);
    w = directed_word(OP_JP_NZ, 4'h8); w.cycles_taken = '1; w.cycles_not_taken = '0;
    queue_word(w, 0);
    w = directed_word(OP_JP_HL, 4'hF); w.hl = 16'hFFFF; queue_word(w, 0);
    w = directed_word(OP_JR, 4'h0); w.imm_value = 16'hFF80; w.pc = 16'h0010;
    queue_word(w, 1);
    w = directed_word(OP_JR_NC, 4'h0); w.imm_value = 16'h007F; w.pc = 16'hFFF0;
    queue_word(w, 0);
    w = directed_word(OP_JR_Z, 4'h7); queue_word(w, 0);
    w = directed_word(OP_CALL, 4'h0); w.sp = 16'h0000; queue_word(w, 2);
    w = directed_word(OP_CALL_NC, 4'h1); queue_word(w, 0);
    w = directed_word(OP_CALL_Z, 4'h8); w.sp = 16'h0001; queue_word(w, 0);
    w = directed_word(OP_RET, 4'h0); w.sp = 16'hFFFE; queue_word(w, 0);
    w = directed_word(OP_RET_NZ, 4'hF); queue_word(w, 1);
    w = directed_word(OP_RETI, 4'h0); w.sp = 16'hFFFF; queue_word(w, 0);
    w = directed_word(OP_RET_C, 4'h1); queue_word(w, 0);
    w = directed_word(OP_RST_38, 4'h0); w.sp = 16'h0000; queue_word(w, 0);
    w = directed_word(OP_PUSH_AF, 4'h0); w.sp = 16'h0001; w.pair_value = 16'hFFFF;
    queue_word(w, 0);
    w = directed_word(OP_POP_AF, 4'h0); w.stack_word = 16'hFFFF; queue_word(w, 0);
    w = directed_word(OP_CP_A, 4'h0); w.reg_a = 8'h5A; w.operand_byte = 8'h5A; queue_word(w, 0);
    w = directed_word(OP_CP_IMM, 4'hF); w.reg_a = 8'h10; w.operand_byte = 8'h01;
    queue_word(w, 0);
    w = directed_word(OP_CP_B, 4'h0); w.reg_a = 8'h00; w.operand_byte = 8'hFF; queue_word(w, 0);
    w = directed_word(OP_CP_MHL, 4'h0); w.reg_a = 8'hFF; w.operand_byte = 8'h00;
    queue_word(w, 0);
    w = directed_word(OP_DI, 4'h5); queue_word(w, 0);
    w = directed_word(OP_EI, 4'hA); queue_word(w, 0);
    w = directed_word(OP_HALT, 4'h3); queue_word(w, 3);

    // Most words carry a handled opcode; the rest sweep the whole opcode byte.
    for (int unsigned n = 0; n < RANDOM_WORDS; n++) begin
      w = random_word();
      if ($urandom_range(0, 99) < 85) w.req_type = flow_ops[$urandom_range(0, flow_ops.size() - 1)];
      if ($urandom_range(0, 7) == 0) w.sp = sp_edges[$urandom_range(0, 3)];
      case ($urandom_range(0, 3))
        0: w.operand_byte = w.reg_a;
        1: w.operand_byte[7:4] = w.reg_a[7:4];
        default: begin
        end
      endcase
      if ($urandom_range(0, 7) == 0) w.imm_value[7:0] = {w.imm_value[0], 7'h00};
      gap = ((n % 200) < 50) ? 0 : $urandom_range(0, 9);
      queue_word(w, gap);
    end
    total = instr_q.size();

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (n_issued < total) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d instructions sent, %0d result words checked, %0d with unknown opcodes",
             n_issued, n_checked, n_unknown);
    if (n_errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d field mismatches", n_errors);
      $display("simulation failed");
    end
    $finish;
  end

endmodule
